[rtl/sdt_pkg.sv]
package sdt_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BITS_DEF    = 48;

    localparam logic [31:0] EXPIRE_AGE_RST    = 32'd90000;
    localparam logic [31:0] CULL_INTERVAL_RST = 32'd60;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISS    = 3'd3,
        ST_PASS    = 3'd4,
        ST_SKIP    = 3'd5
    } status_t;

    localparam logic REG_EXPIRE_AGE    = 1'b0;
    localparam logic REG_CULL_INTERVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_ADD_DEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_FIND_RD,
        S_FIND_DONE,
        S_PASS_RD,
        S_PASS_WR,
        S_OUT
    } state_t;

endpackage

[rtl/sorted_device_table_with_expiry.sv]
// channel  | dir | transfer when         | contents
// ---------+-----+-----------------------+-------------------------------------
// s_axis   | in  | s_tvalid & s_tready   | command, device_key, key_kind, now
// m_axis   | out | m_tvalid & m_tready   | status, slot, kind, seen, counts
// cfg      | in  | cfg_valid & cfg_ready | register index, 32-bit value
//
// one command at a time, all through the one table memory
// add/find: a binary search over the stored entries; an insert first
// moves each entry above the insertion slot up one place (read then write)
// expire pass: reads each stored entry and compacts the kept ones to slot 0
// rst_n clears occupancy and last pass time, registers go to defaults;
// table contents stay undefined. output register holds a result until
// taken; s_tready stays low from acceptance until the result transfer
module sorted_device_table_with_expiry
    import sdt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], device_key[49:2], key_kind[57:50], now_seconds[89:58], zero fill
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], slot[13:3], found_kind[21:14], found_seen[53:22],
    // entry_count[64:54], expired_count[75:65], zero fill
    output logic [79:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = KEY_BITS + 40;

    // key, kind, seen share one entry word
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    sdt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [KEY_BITS-1:0] rd_key;
    logic [7:0]          rd_kind;
    logic [31:0]         rd_seen;
    assign rd_key  = ram_rdata[KEY_BITS-1:0];
    assign rd_kind = ram_rdata[KEY_BITS+7:KEY_BITS];
    assign rd_seen = ram_rdata[EW-1:KEY_BITS+8];

    state_t state_reg, state_next;

    logic [31:0] age_reg, interval_reg, last_pass_reg;
    logic [CW-1:0] occ_reg;
    cmd_t          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [7:0]    kind_reg;
    logic [31:0]   now_reg, limit_reg;
    // search bounds, signed-style with lo starting at -1
    logic [CW:0]   lo_reg, hi_reg;
    logic [CW-1:0] mid_reg, rd_ptr_reg, wr_ptr_reg;
    logic [EW-1:0] hold_reg;
    logic [79:0]   out_reg;
    logic          out_valid_reg;

    logic [CW:0] mid_calc;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    priority case (cmd_t'(s_tdata[1:0]))
                        CMD_ADD, CMD_FIND: state_next = S_SRCH_RD;
                        CMD_EXPIRE:        state_next = S_PASS_RD;
                        default:           state_next = S_OUT;
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (hi_reg - lo_reg == {{CW{1'b0}}, 1'b1})
                    state_next = (cmd_reg == CMD_ADD) ? S_ADD_DEC : S_OUT;
                else
                    state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (key_reg == rd_key)
                    state_next = (cmd_reg == CMD_ADD) ? S_OUT : S_OUT;
                else
                    state_next = S_SRCH_RD;
            end
            S_ADD_DEC:  state_next = (occ_reg == CW'(TABLE_DEPTH)) ? S_OUT :
                                     (occ_reg == hi_reg[CW-1:0]) ? S_INSERT : S_SHIFT_RD;
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = (rd_ptr_reg - 1'b1 == hi_reg[CW-1:0]) ? S_INSERT
                                                                           : S_SHIFT_RD;
            S_INSERT:   state_next = S_OUT;
            S_FIND_RD:  state_next = S_FIND_DONE;
            S_FIND_DONE: state_next = S_OUT;
            S_PASS_RD:  state_next = (rd_ptr_reg == occ_reg) ? S_OUT : S_PASS_WR;
            S_PASS_WR:  state_next = S_PASS_RD;
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[AW-1:0];
        ram_wdata = hold_reg;
        ram_raddr = rd_ptr_reg[AW-1:0];
        unique case (state_reg)
            S_SRCH_RD:  ram_raddr = mid_calc[AW-1:0];
            S_SHIFT_RD: ram_raddr = AW'(rd_ptr_reg - 1'b1);
            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = rd_ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_INSERT:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg[AW-1:0];
                ram_wdata = {now_reg, kind_reg, key_reg};
            end
            S_SRCH_CMP:
            begin
                ram_we    = (cmd_reg == CMD_ADD) && (key_reg == rd_key);
                ram_waddr = mid_reg[AW-1:0];
                ram_wdata = {now_reg, rd_kind, rd_key};
            end
            S_PASS_WR:
            begin
                ram_we    = (rd_seen >= limit_reg) && (rd_ptr_reg != wr_ptr_reg + 1'b1);
                ram_waddr = wr_ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            default: ;
        endcase
    end

    function automatic logic [79:0] pack(status_t st, logic [CW-1:0] sl, logic [7:0] kd,
                                         logic [31:0] sn, logic [CW-1:0] oc,
                                         logic [CW-1:0] ex);
        pack = {4'd0, 11'(ex), 11'(oc), sn, kd, 11'(sl), st};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            age_reg       <= EXPIRE_AGE_RST;
            interval_reg  <= CULL_INTERVAL_RST;
            last_pass_reg <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_EXPIRE_AGE) age_reg <= cfg_data;
                else                             interval_reg <= cfg_data;
            end
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cmd_reg    <= cmd_t'(s_tdata[1:0]);
                        key_reg    <= s_tdata[2 +: KEY_BITS];
                        kind_reg   <= s_tdata[57:50];
                        now_reg    <= s_tdata[89:58];
                        limit_reg  <= s_tdata[89:58] - age_reg;
                        lo_reg     <= '1;
                        hi_reg     <= {1'b0, occ_reg};
                        if (cmd_t'(s_tdata[1:0]) == CMD_EXPIRE)
                        begin
                            if (s_tdata[89:58] >= last_pass_reg &&
                                (s_tdata[89:58] - last_pass_reg) > interval_reg)
                            begin
                                last_pass_reg <= s_tdata[89:58];
                                out_reg <= pack(ST_PASS, '0, '0, '0, occ_reg, '0);
                                // before expire_age nothing is scanned or removed
                                if (s_tdata[89:58] < age_reg)
                                begin
                                    rd_ptr_reg <= occ_reg;
                                    wr_ptr_reg <= occ_reg;
                                end
                                else
                                begin
                                    rd_ptr_reg <= '0;
                                    wr_ptr_reg <= '0;
                                end
                            end
                            else
                            begin
                                rd_ptr_reg <= occ_reg;
                                wr_ptr_reg <= '0;
                                out_reg <= pack(ST_SKIP, '0, '0, '0, occ_reg, '0);
                            end
                        end
                        else
                        begin
                            rd_ptr_reg <= '0;
                            wr_ptr_reg <= '0;
                            out_reg    <= pack(ST_MISS, '0, '0, '0, occ_reg, '0);
                        end
                    end
                end
                S_SRCH_RD: mid_reg <= mid_calc[CW-1:0];
                S_SRCH_CMP:
                begin
                    if (key_reg < rd_key)
                        hi_reg <= {1'b0, mid_reg};
                    else if (key_reg > rd_key)
                        lo_reg <= {1'b0, mid_reg};
                    else if (cmd_reg == CMD_ADD)
                        out_reg <= pack(ST_HIT, mid_reg, rd_kind, now_reg, occ_reg, '0);
                    else
                        out_reg <= pack(ST_HIT, mid_reg, rd_kind, rd_seen, occ_reg, '0);
                end
                S_ADD_DEC:
                begin
                    rd_ptr_reg <= occ_reg;
                    if (occ_reg == CW'(TABLE_DEPTH))
                        out_reg <= pack(ST_FULL, '0, '0, '0, occ_reg, '0);
                end
                S_SHIFT_WR: rd_ptr_reg <= rd_ptr_reg - 1'b1;
                S_INSERT:
                begin
                    occ_reg <= occ_reg + 1'b1;
                    out_reg <= pack(ST_ADDED, hi_reg[CW-1:0], kind_reg, now_reg,
                                    occ_reg + 1'b1, '0);
                end
                S_PASS_RD:
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    if (rd_ptr_reg == occ_reg && out_reg[2:0] == ST_PASS)
                    begin
                        occ_reg <= wr_ptr_reg;
                        out_reg <= pack(ST_PASS, '0, '0, '0, wr_ptr_reg,
                                        occ_reg - wr_ptr_reg);
                    end
                end
                S_PASS_WR:
                begin
                    if (rd_seen >= limit_reg)
                        wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
                S_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
        hold_reg <= ram_rdata;

endmodule

[rtl/sdt_ram.sv]
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sdt_checker.sv]
module sdt_checker
    import sdt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_SKIP)
        else $error("bad status");

    a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_PASS |-> m_tdata[75:65] == 11'd0)
        else $error("expired count outside a pass");

endmodule

bind sorted_device_table_with_expiry sdt_checker u_sdt_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/sdt_table_checker.sv]
module sdt_table_checker
    import sdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        status_t     status;
        logic [10:0] slot;
        logic [7:0]  kind;
        logic [31:0] seen;
        logic [10:0] count;
        logic [10:0] expired;
    } lookup_result_t;

    logic [47:0] dev_key  [DEPTH];
    logic [7:0]  dev_kind [DEPTH];
    logic [31:0] dev_seen [DEPTH];
    int          occ;
    logic [31:0] last_pass;
    logic [31:0] age_limit;
    logic [31:0] pass_gap;
    lookup_result_t awaited_results[$];

    assign pending = awaited_results.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit locate(input logic [47:0] key, output int pos);
        int lo;
        int hi;
        int mid;
        lo = -1;
        hi = occ;
        while (hi - lo != 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < dev_key[mid])
                hi = mid;
            else if (key > dev_key[mid])
                lo = mid;
            else
            begin
                pos = mid;
                return 1;
            end
        end
        pos = hi;
        return 0;
    endfunction

    task automatic predict_lookup(input logic [95:0] item);
        cmd_t           cmd;
        logic [47:0]    key;
        logic [7:0]     kind;
        logic [31:0]    now;
        lookup_result_t r;
        int             pos;
        int             wr;
        bit             hit;
        cmd  = cmd_t'(item[1:0]);
        key  = item[49:2];
        kind = item[57:50];
        now  = item[89:58];
        r = '0;
        r.status = ST_MISS;
        pos = 0;
        case (cmd)
            CMD_ADD:
            begin
                hit = (occ > 0) ? locate(key, pos) : 0;
                if (hit)
                begin
                    dev_seen[pos] = now;
                    r.status = ST_HIT;
                    r.slot = 11'(pos);
                    r.kind = dev_kind[pos];
                    r.seen = now;
                end
                else if (occ < DEPTH)
                begin
                    for (int i = occ; i > pos; i--)
                    begin
                        dev_key[i]  = dev_key[i-1];
                        dev_kind[i] = dev_kind[i-1];
                        dev_seen[i] = dev_seen[i-1];
                    end
                    dev_key[pos]  = key;
                    dev_kind[pos] = kind;
                    dev_seen[pos] = now;
                    occ++;
                    r.status = ST_ADDED;
                    r.slot = 11'(pos);
                    r.kind = kind;
                    r.seen = now;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_FIND:
            begin
                if (occ > 0 && locate(key, pos))
                begin
                    r.status = ST_HIT;
                    r.slot = 11'(pos);
                    r.kind = dev_kind[pos];
                    r.seen = dev_seen[pos];
                end
            end
            CMD_EXPIRE:
            begin
                if (now >= last_pass && (now - last_pass) > pass_gap)
                begin
                    // nothing goes while now is still below the age
                    if (now >= age_limit)
                    begin
                        wr = 0;
                        for (int rd = 0; rd < occ; rd++)
                        begin
                            if (dev_seen[rd] < now - age_limit)
                                r.expired++;
                            else
                            begin
                                dev_key[wr]  = dev_key[rd];
                                dev_kind[wr] = dev_kind[rd];
                                dev_seen[wr] = dev_seen[rd];
                                wr++;
                            end
                        end
                        occ = wr;
                    end
                    last_pass = now;
                    r.status = ST_PASS;
                end
                else
                    r.status = ST_SKIP;
            end
            default: ;
        endcase
        r.count = 11'(occ);
        awaited_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t got;
        lookup_result_t want;
        if (!rst_n)
        begin
            occ = 0;
            last_pass = '0;
            age_limit = EXPIRE_AGE_RST;
            pass_gap = CULL_INTERVAL_RST;
            awaited_results.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status  = status_t'(m_tdata[2:0]);
                got.slot    = m_tdata[13:3];
                got.kind    = m_tdata[21:14];
                got.seen    = m_tdata[53:22];
                got.count   = m_tdata[64:54];
                got.expired = m_tdata[75:65];
                if (awaited_results.size() == 0)
                    report("unexpected result transfer", m_tdata[63:0], 64'd0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status != want.status)
                        report("status", 64'(got.status), 64'(want.status));
                    if (got.slot != want.slot)
                        report("slot", 64'(got.slot), 64'(want.slot));
                    if (got.kind != want.kind)
                        report("found_kind", 64'(got.kind), 64'(want.kind));
                    if (got.seen != want.seen)
                        report("found_seen", 64'(got.seen), 64'(want.seen));
                    if (got.count != want.count)
                        report("entry_count", 64'(got.count), 64'(want.count));
                    if (got.expired != want.expired)
                        report("expired_count", 64'(got.expired), 64'(want.expired));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EXPIRE_AGE)
                    age_limit = cfg_data;
                else
                    pass_gap = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_lookup(s_tdata);
        end
    end
endmodule

[tb/tb_sorted_device_table_with_expiry.sv]
module tb_sorted_device_table_with_expiry;
    import sdt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transfer on any channel before the run is abandoned;
    // worst item is a full-table pass or shift (a read and a write per entry)
    // plus the long receiver hold-off
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int errors;
    int pending;

    // idle percentages for each side, set per phase
    int tx_idle_pct;
    int rx_stall_pct;
    // each bump of the ticket starts one long receiver hold-off
    int hold_ticket;
    int hold_taken;
    int hold_left;
    int quiet_cycles;

    // running wall clock handed to the block, plus a pool of repeat addresses
    logic [31:0] wall_now;
    logic [47:0] addr_pool[48];

    sorted_device_table_with_expiry dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    sdt_table_checker table_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_taken != hold_ticket)
        begin
            hold_taken <= hold_ticket;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog: counts cycles in which no transfer happens anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one command transfer; called at a rising edge, returns at the edge that
    // took it with tvalid still high
    task automatic send_cmd(input cmd_t cmd, input logic [47:0] key,
                            input logic [7:0] kind, input logic [31:0] now);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, now, kind, key, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // lets every outstanding result drain before anything touches the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed traffic around a small address pool with time moving
    // forward; now and then a fresh address, an unused command, or time jumping
    task automatic random_traffic(input int count);
        cmd_t        cmd;
        logic [47:0] key;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                cmd = CMD_ADD;
            else if (pick < 75)
                cmd = CMD_FIND;
            else if (pick < 95)
                cmd = CMD_EXPIRE;
            else
                cmd = CMD_NONE;
            if ($urandom_range(99) < 75)
                key = addr_pool[$urandom_range(47)];
            else
                key = 48'({$urandom, $urandom});
            pick = $urandom_range(99);
            if (pick < 3)
                wall_now = wall_now - $urandom_range(500);
            else if (pick < 5)
                wall_now = $urandom;
            else
                wall_now = wall_now + $urandom_range(40);
            send_cmd(cmd, key, 8'($urandom), wall_now);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_EXPIRE_AGE;
        cfg_data    <= '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_ticket  = 0;
        wall_now     = 32'd1000;
        for (int i = 0; i < 48; i++)
            addr_pool[i] = 48'({$urandom, $urandom});
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: key extremes, refresh, find hit and miss, unused command
        send_cmd(CMD_FIND, 48'h0, 8'h00, 32'd0);
        send_cmd(CMD_ADD, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'd5);
        send_cmd(CMD_ADD, 48'h0, 8'h00, 32'd6);
        send_cmd(CMD_ADD, 48'h8000_0000_0000, 8'h5A, 32'd7);
        send_cmd(CMD_ADD, 48'h5555_5555_5555, 8'hA5, 32'd8);
        send_cmd(CMD_ADD, 48'h8000_0000_0000, 8'h11, 32'd9);
        send_cmd(CMD_FIND, 48'hFFFF_FFFF_FFFF, 8'h00, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 48'h0, 8'hFF, 32'd0);
        send_cmd(CMD_FIND, 48'h1234_5678_9ABC, 8'h00, 32'd0);
        send_cmd(CMD_NONE, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        // interval not yet elapsed, then a pass run while now is below the age
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd0);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd60);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd61);
        // time going backwards skips the pass
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd20);
        send_cmd(CMD_ADD, 48'h0, 8'h00, 32'd100000);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd100000);

        // smallest age and no interval: the next pass clears every entry
        write_reg(REG_EXPIRE_AGE, 32'd1);
        write_reg(REG_CULL_INTERVAL, 32'd0);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd200000);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd200000);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd200001);

        // descending keys so every add lands in slot 0 and shifts the rest up
        for (int i = 0; i < 60; i++)
            send_cmd(CMD_ADD, 48'h1_0000 + 48'(59 - i), i[7:0], 32'd300000);
        send_cmd(CMD_ADD, 48'h5, 8'h77, 32'd300000);
        send_cmd(CMD_ADD, 48'h1_0000, 8'h77, 32'd300001);
        send_cmd(CMD_FIND, 48'h1_003B, 8'h00, 32'd0);
        // pass over the filled table removes everything
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'd400000);

        // largest interval: no pass can ever run
        write_reg(REG_CULL_INTERVAL, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 48'h42, 8'h01, 32'd1);
        send_cmd(CMD_EXPIRE, 48'h0, 8'h00, 32'hFFFF_FFFF);

        // largest age with a modest interval
        write_reg(REG_EXPIRE_AGE, 32'hFFFF_FFFF);
        write_reg(REG_CULL_INTERVAL, 32'd30);
        wall_now = 32'd500000;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        random_traffic(100);

        // short age so entries actually age out during the random part
        write_reg(REG_EXPIRE_AGE, 32'd300);
        write_reg(REG_CULL_INTERVAL, 32'd60);
        tx_idle_pct = 86;
        random_traffic(120);

        tx_idle_pct  = 0;
        rx_stall_pct = 86;
        random_traffic(120);

        // long receiver hold-off while the sender keeps offering
        rx_stall_pct = 0;
        hold_ticket++;
        random_traffic(6);
        // sender pauses until all results are back
        drain();

        write_reg(REG_EXPIRE_AGE, 32'd150);
        write_reg(REG_CULL_INTERVAL, 32'd0);
        tx_idle_pct  = 22;
        rx_stall_pct = 22;
        random_traffic(120);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        random_traffic(30);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[sorted_device_table_with_expiry.f]
rtl/sdt_pkg.sv
rtl/sdt_ram.sv
rtl/sorted_device_table_with_expiry.sv
rtl/sdt_checker.sv
tb/sdt_table_checker.sv
tb/tb_sorted_device_table_with_expiry.sv
